// ===== rtl/ffba_pkg.sv =====
// Shared types and constants for the first-fit block bitmap allocator.
// No dependencies; imported by ffba_ring and the allocator core.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int NUM_BLOCKS_DEF = 128;

  localparam int FUNC_W     = 2;
  localparam int BLOCK_W    = 7;
  localparam int RUN_LEN_W  = 8;

  localparam logic [FUNC_W-1:0] FUNC_FIND      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK_USED = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK_FREE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TEST      = 2'd3;

  // Control from the scan sequencer to the bitmap ring.
  typedef struct packed {
    logic shift;   // rotate the ring by one block
    logic wr_bit;  // value re-entering the tail cell
  } ring_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ffba_cell.sv =====
// One bitmap cell: the used bit of one block, loaded from its neighbor on shift.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ffba_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire logic d,
  output logic      q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffba_ring.sv =====
// Circular chain of bitmap cells; cell 0 is the head seen by the sequencer.
// Depends on ffba_pkg and ffba_cell.
`timescale 1ns / 1ps
`default_nettype none

module ffba_ring
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ring_ctrl_t ctrl,
  output logic            head
);

  logic [NUM_BLOCKS-1:0] q;

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    logic d;
    if (i == NUM_BLOCKS - 1) begin : g_tail
      assign d = ctrl.wr_bit;
    end else begin : g_mid
      assign d = q[i+1];
    end
    ffba_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctrl.shift),
      .d     (d),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_bitmap_allocator_core.sv =====
// First-fit block bitmap allocator. The used bits of NUM_BLOCKS blocks sit in a
// ring of cells that rotates one block per cycle past a single head cell, except
// while a scan is stalled; every request (find free run, mark used, mark free,
// test) makes exactly one full rotation, and no new request is accepted until
// that rotation ends. The result is held in an output register; a new request
// is taken while a result still waits, and a scan pauses on its last block only
// if the previous result has not been transferred yet.
// Depends on ffba_pkg and ffba_ring.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_bitmap_allocator_core
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [BLOCK_W-1:0]   first_block,
  input  wire logic [RUN_LEN_W-1:0] run_length,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      ok,
  output logic [BLOCK_W-1:0]        block,
  output logic                      block_used
);

  localparam int STEP_W = $clog2(NUM_BLOCKS);
  localparam int W      = (STEP_W + 1 > 10) ? STEP_W + 1 : 10;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_BLOCKS - 1);
  localparam logic [W-1:0]      NUM_W     = W'(NUM_BLOCKS);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t               state;
  logic [STEP_W-1:0]    step;
  logic [FUNC_W-1:0]    cur_func;
  logic [BLOCK_W-1:0]   cur_first;
  logic [RUN_LEN_W-1:0] cur_len;
  logic [RUN_LEN_W-1:0] run;
  logic                 found;
  logic [BLOCK_W-1:0]   blk;
  logic                 used;

  ring_ctrl_t ring_ctrl;
  logic       head;

  logic [W-1:0]         k_w, first_w, end_w, start_w;
  logic                 in_range, in_mark, last, load;
  logic [RUN_LEN_W:0]   run_inc;
  logic [RUN_LEN_W-1:0] run_next;
  logic                 hit, found_next, used_next;
  logic [BLOCK_W-1:0]   blk_next;
  logic                 ok_next;

  ffba_ring #(.NUM_BLOCKS(NUM_BLOCKS)) u_ring (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ring_ctrl),
    .head (head)
  );

  assign in_ready = (state == IDLE);

  assign k_w      = W'(step);
  assign first_w  = W'(cur_first);
  assign end_w    = first_w + W'(cur_len);
  assign in_range = (k_w >= first_w);
  assign in_mark  = in_range && (k_w < end_w);
  assign last     = (step == LAST_STEP);
  assign load     = (state == SCAN) && last && (!out_valid || out_ready);
  assign run_inc  = {1'b0, run} + 1'b1;
  assign start_w  = k_w + W'(1) - W'(cur_len);

  always_comb begin
    run_next   = run;
    hit        = 1'b0;
    used_next  = used;
    ring_ctrl.shift  = (state == SCAN) && (!last || load);
    ring_ctrl.wr_bit = head;
    unique case (cur_func)
      FUNC_FIND: begin
        if (in_range && !found) begin
          if (head) begin
            run_next = '0;
          end else begin
            run_next = run_inc[RUN_LEN_W-1:0];
            hit      = (cur_len != '0) && (run_inc == {1'b0, cur_len});
          end
        end
      end
      FUNC_MARK_USED, FUNC_MARK_FREE: begin
        if (in_mark) begin
          ring_ctrl.wr_bit = (cur_func == FUNC_MARK_USED);
        end
      end
      FUNC_TEST: begin
        if (k_w == first_w) begin
          used_next = head;
        end
      end
      default: ;
    endcase
    found_next = found | hit;
    blk_next   = hit ? start_w[BLOCK_W-1:0] : blk;
    case (cur_func)
      FUNC_FIND:                      ok_next = (cur_len == '0) || found_next;
      FUNC_MARK_USED, FUNC_MARK_FREE: ok_next = (end_w <= NUM_W);
      default:                        ok_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state     <= SCAN;
            step      <= '0;
            cur_func  <= func;
            cur_first <= first_block;
            cur_len   <= run_length;
            run       <= '0;
            found     <= 1'b0;
            blk       <= first_block;
            used      <= 1'b0;
          end
        end
        SCAN: begin
          if (ring_ctrl.shift) begin
            run   <= run_next;
            found <= found_next;
            blk   <= blk_next;
            used  <= used_next;
            step  <= last ? '0 : step + 1'b1;
          end
          if (load) begin
            state      <= IDLE;
            out_valid  <= 1'b1;
            ok         <= ok_next;
            block      <= blk_next;
            block_used <= (cur_func == FUNC_TEST) && used_next;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // The ring must be back in alignment whenever no scan runs.
  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    state == IDLE |-> step == '0)
    else $error("step counter not at zero while idle");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN && !ring_ctrl.shift) |-> (last && out_valid && !out_ready))
    else $error("ring stalled without a pending result");

  a_load_ends_scan: assert property (@(posedge clk) disable iff (rst)
    load |=> (state == IDLE && out_valid))
    else $error("result load did not end the scan");

  a_found_only_on_find: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN && found) |-> cur_func == FUNC_FIND)
    else $error("run found outside a find request");

endmodule

`default_nettype wire
